// File: src/qvr_pkg.sv
// shared widths, payload types and divider lane types for the quaternion rotator
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

   localparam int unsigned VEC_W = 32;          // vector component width
   localparam int unsigned QW    = 16;          // quaternion component width
   localparam int unsigned PRW   = 2 * QW;      // product of two quaternion components
   localparam int unsigned NW    = PRW + 1;     // squared norm
   localparam int unsigned MW    = PRW + 2;     // scaled rotation matrix entry
   localparam int unsigned PW    = MW + VEC_W;  // matrix entry times vector component
   localparam int unsigned SW    = PW + 2;      // sum of three products
   localparam int unsigned QB    = VEC_W + 1;   // quotient bits, one per divider cell
   localparam int unsigned LANES = 3;

   typedef struct packed {
      logic signed [QW-1:0]    q_real;
      logic signed [QW-1:0]    q_i;
      logic signed [QW-1:0]    q_j;
      logic signed [QW-1:0]    q_k;
      logic signed [VEC_W-1:0] vec_x;
      logic signed [VEC_W-1:0] vec_y;
      logic signed [VEC_W-1:0] vec_z;
   } qvr_req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] rot_x;
      logic signed [VEC_W-1:0] rot_y;
      logic signed [VEC_W-1:0] rot_z;
      logic                    zero_norm;
      logic                    saturated;
   } qvr_rsp_type;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [QB-1:0] dvd;
      logic [QB-1:0] quo;
      logic          neg;
   } qvr_lane_type;

   typedef struct packed {
      logic                     vld;
      logic [NW-1:0]            n;
      qvr_lane_type [LANES-1:0] lane;
   } qvr_div_type;

endpackage
`default_nettype wire

// File: src/quaternion_vector_rotate_top.sv
// top level of the quaternion vector rotator
`timescale 1ns / 1ps
`default_nettype none
// Rotates a Q16.16 vector by a Q2.14 quaternion as q*v*conj(q)/|q|^2, so the
// quaternion need not be unit length; results are rounded half away from zero
// and saturated, and a zero quaternion gives a zero vector with zero_norm set.
// One beat is taken every cycle while the output side keeps up; each beat
// passes through the multiply-and-sum registers (stages a to d), one divider
// cell per quotient bit (VEC_W + 1 cells, all three components in each) and
// the output register. The whole pipeline holds while a result waits.
module quaternion_vector_rotate_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire qvr_pkg::qvr_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output qvr_pkg::qvr_rsp_type      rsp_data
);
   localparam int unsigned QB = qvr_pkg::QB;

   logic                 adv;
   qvr_pkg::qvr_div_type chain [QB+1];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   qvr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .div_out   (chain[0])
   );

   for (genvar k = 0; k < QB; k++) begin : g_cell
      qvr_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .div_in  (chain[k]),
         .div_out (chain[k+1])
      );
   end

   qvr_round u_round (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .div_in    (chain[QB]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: src/qvr_front.sv
// products, scaled matrix, matrix-vector sums and divider setup
`timescale 1ns / 1ps
`default_nettype none
module qvr_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 req_valid,
   input  wire qvr_pkg::qvr_req_type req_data,
   output qvr_pkg::qvr_div_type      div_out
);
   localparam int unsigned PRW = qvr_pkg::PRW;
   localparam int unsigned MW  = qvr_pkg::MW;
   localparam int unsigned NW  = qvr_pkg::NW;
   localparam int unsigned PW  = qvr_pkg::PW;
   localparam int unsigned SW  = qvr_pkg::SW;
   localparam int unsigned QB  = qvr_pkg::QB;
   localparam int unsigned VW  = qvr_pkg::VEC_W;

   logic a_vld_ff, b_vld_ff, c_vld_ff;
   logic signed [PRW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic signed [VW-1:0]  av_ff [3];
   logic signed [VW-1:0]  bv_ff [3];
   logic signed [MW-1:0]  m_ff [9];
   logic [NW-1:0]         bn_ff, cn_ff;
   logic signed [PW-1:0]  p_ff [9];
   qvr_pkg::qvr_div_type  div_ff, div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   // stage a: component products
   always_ff @(posedge clock) begin
      if (adv) begin
         ww_ff <= req_data.q_real * req_data.q_real;
         xx_ff <= req_data.q_i * req_data.q_i;
         yy_ff <= req_data.q_j * req_data.q_j;
         zz_ff <= req_data.q_k * req_data.q_k;
         xy_ff <= req_data.q_i * req_data.q_j;
         wz_ff <= req_data.q_real * req_data.q_k;
         xz_ff <= req_data.q_i * req_data.q_k;
         wy_ff <= req_data.q_real * req_data.q_j;
         yz_ff <= req_data.q_j * req_data.q_k;
         wx_ff <= req_data.q_real * req_data.q_i;
         av_ff[0] <= req_data.vec_x;
         av_ff[1] <= req_data.vec_y;
         av_ff[2] <= req_data.vec_z;
      end
   end

   // stage b: rotation matrix scaled by the norm
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0] <= MW'(ww_ff) + MW'(xx_ff) - MW'(yy_ff) - MW'(zz_ff);
         m_ff[1] <= (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
         m_ff[2] <= (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
         m_ff[3] <= (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
         m_ff[4] <= MW'(ww_ff) - MW'(xx_ff) + MW'(yy_ff) - MW'(zz_ff);
         m_ff[5] <= (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
         m_ff[6] <= (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
         m_ff[7] <= (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
         m_ff[8] <= MW'(ww_ff) - MW'(xx_ff) - MW'(yy_ff) + MW'(zz_ff);
         bn_ff   <= NW'($unsigned(ww_ff)) + NW'($unsigned(xx_ff))
                  + NW'($unsigned(yy_ff)) + NW'($unsigned(zz_ff));
         for (int i = 0; i < 3; i++) begin
            bv_ff[i] <= av_ff[i];
         end
      end
   end

   // stage c: nine matrix-vector products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            p_ff[i] <= m_ff[i] * bv_ff[i % 3];
         end
         cn_ff <= bn_ff;
      end
   end

   // stage d: row sums, split into sign and magnitude for the divider
   always_comb begin
      logic signed [SW-1:0] sum;
      logic [SW-1:0]        mag;
      div_in     = '0;
      div_in.vld = c_vld_ff;
      div_in.n   = cn_ff;
      for (int r = 0; r < 3; r++) begin
         sum = SW'(p_ff[3*r]) + SW'(p_ff[3*r+1]) + SW'(p_ff[3*r+2]);
         mag = sum[SW-1] ? $unsigned(-sum) : $unsigned(sum);
         div_in.lane[r].neg = sum[SW-1];
         // the quotient fits in QB bits, so the top part is already below n
         div_in.lane[r].rem = mag[QB+NW-1:QB];
         div_in.lane[r].dvd = mag[QB-1:0];
         div_in.lane[r].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.vld <= 1'b0;
      end else if (adv) begin
         div_ff.vld <= div_in.vld;
      end
      if (adv) begin
         div_ff.n    <= div_in.n;
         div_ff.lane <= div_in.lane;
      end
   end

   assign div_out = div_ff;

endmodule
`default_nettype wire

// File: src/qvr_div_cell.sv
// one restoring-division cell: one quotient bit for each of the three lanes
`timescale 1ns / 1ps
`default_nettype none
module qvr_div_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire qvr_pkg::qvr_div_type div_in,
   output qvr_pkg::qvr_div_type      div_out
);
   localparam int unsigned NW = qvr_pkg::NW;
   localparam int unsigned QB = qvr_pkg::QB;

   qvr_pkg::qvr_div_type div_ff, nxt;

   always_comb begin
      logic [NW:0] t;
      logic        ge;
      nxt = div_in;
      for (int r = 0; r < qvr_pkg::LANES; r++) begin
         t  = {div_in.lane[r].rem, div_in.lane[r].dvd[QB-1]};
         ge = t >= {1'b0, div_in.n};
         nxt.lane[r].rem = ge ? NW'(t - {1'b0, div_in.n}) : t[NW-1:0];
         nxt.lane[r].dvd = {div_in.lane[r].dvd[QB-2:0], 1'b0};
         nxt.lane[r].quo = {div_in.lane[r].quo[QB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.vld <= 1'b0;
      end else if (adv) begin
         div_ff.vld <= nxt.vld;
      end
      if (adv) begin
         div_ff.n    <= nxt.n;
         div_ff.lane <= nxt.lane;
      end
   end

   assign div_out = div_ff;

endmodule
`default_nettype wire

// File: src/qvr_round.sv
// rounding, saturation and zero-norm handling into the output register
`timescale 1ns / 1ps
`default_nettype none
module qvr_round (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire qvr_pkg::qvr_div_type div_in,
   output logic                      rsp_valid,
   output qvr_pkg::qvr_rsp_type      rsp_data
);
   localparam int unsigned QB = qvr_pkg::QB;
   localparam int unsigned VW = qvr_pkg::VEC_W;

   logic                 vld_ff;
   qvr_pkg::qvr_rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [QB:0]        q1;
      logic [QB:0]        bound;
      logic [VW-1:0]      mag;
      logic               inc, sat;
      logic [VW-1:0]      res [3];
      sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
         // round half away from zero on the magnitude
         inc   = {div_in.lane[r].rem, 1'b0} >= {1'b0, div_in.n};
         q1    = {1'b0, div_in.lane[r].quo} + (QB+1)'(inc);
         bound = div_in.lane[r].neg ? (QB+1)'(1) << (VW-1)
                                    : ((QB+1)'(1) << (VW-1)) - (QB+1)'(1);
         if (q1 > bound) begin
            sat = 1'b1;
            mag = bound[VW-1:0];
         end else begin
            mag = q1[VW-1:0];
         end
         res[r] = div_in.lane[r].neg ? -mag : mag;
      end
      if (div_in.n == '0) begin
         rsp_in = '0;
         rsp_in.zero_norm = 1'b1;
      end else begin
         rsp_in.rot_x     = res[0];
         rsp_in.rot_y     = res[1];
         rsp_in.rot_z     = res[2];
         rsp_in.zero_norm = 1'b0;
         rsp_in.saturated = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= div_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
